### src/npf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npf_pkg
// Widths and base character codes shared by the nucleotide prefix
// fingerprint block and its channel interfaces, and the block's result record.
// ----------------------------------------------------------------------------
package npf_pkg;

	localparam int CHAR_W    = 8;
	localparam int WORD_W    = 32;
	localparam int NUM_BASES = 4;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [WORD_W-1:0] word_t;

	// Counted bases in fingerprint order A, C, G, T.
	localparam char_t CHAR_A = 8'h41;
	localparam char_t CHAR_C = 8'h43;
	localparam char_t CHAR_G = 8'h47;
	localparam char_t CHAR_T = 8'h54;

	localparam char_t BASE_CHARS [NUM_BASES] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

	// Finished fingerprint as held in the output buffer. prod is
	// count * (length + 1); the suffix sum is prod - prefix.
	typedef struct packed {
		word_t [NUM_BASES-1:0] prefix;
		word_t [NUM_BASES-1:0] prod;
	} result_t;

endpackage

### src/npf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npf_if
// Valid/ready channels of the nucleotide prefix fingerprint block: the
// character stream in and the fingerprint result out.
// ----------------------------------------------------------------------------
interface npf_char_if
	import npf_pkg::*;
();
	logic  valid;
	logic  ready;
	char_t base_char;
	logic  last_char;

	modport source (output valid, output base_char, output last_char, input ready);
	modport sink   (input valid, input base_char, input last_char, output ready);
endinterface

interface npf_fp_if
	import npf_pkg::*;
();
	logic  valid;
	logic  ready;
	word_t prefix_sum_a;
	word_t prefix_sum_c;
	word_t prefix_sum_g;
	word_t prefix_sum_t;
	word_t suffix_sum_a;
	word_t suffix_sum_c;
	word_t suffix_sum_g;
	word_t suffix_sum_t;

	modport source (
		output valid,
		output prefix_sum_a, output prefix_sum_c, output prefix_sum_g, output prefix_sum_t,
		output suffix_sum_a, output suffix_sum_c, output suffix_sum_g, output suffix_sum_t,
		input  ready
	);
	modport sink (
		input  valid,
		input  prefix_sum_a, input prefix_sum_c, input prefix_sum_g, input prefix_sum_t,
		input  suffix_sum_a, input suffix_sum_c, input suffix_sum_g, input suffix_sum_t,
		output ready
	);
endinterface

### src/nucleotide_prefix_fingerprint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nucleotide_prefix_fingerprint
// Streams a DNA sequence and emits its eight-word prefix/suffix fingerprint.
// ----------------------------------------------------------------------------
// Usage:
//   seq_in carries one ASCII character per transfer; last_char marks the
//   end of a sequence. Uppercase A, C, G, T are counted, anything else only
//   advances the position.
//   fp_out carries one transfer per sequence: the prefix sums and suffix
//   sums of A, C, G, T, all modulo 2^32.
// Throughput: one character per cycle while seq_in is ready. Per-base
//   counts, prefix sums and count * (length + 1) products are kept in
//   registers and updated with adds only.
// Output: a fingerprint is buffered as its last character is transferred;
//   each suffix word is one subtract after the result register.
// Stall: a two-entry result buffer sits in front of fp_out. seq_in stays
//   ready while the second entry is free, so characters keep flowing while
//   one finished fingerprint waits; seq_in stalls only with both full.
// Reset: arst_n clears the sequence state and empties the result buffer.
//   The state also returns to zero after every last character.
// ----------------------------------------------------------------------------
module nucleotide_prefix_fingerprint
	import npf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	npf_char_if.sink   seq_in,
	npf_fp_if.source   fp_out
);

	word_t [NUM_BASES-1:0] cnt_q, pre_q, prod_q;
	word_t                 len_q;

	word_t [NUM_BASES-1:0] cnt_n, pre_n, prod_n;
	logic  [NUM_BASES-1:0] hit;
	word_t                 len_plus2;

	result_t head_q, skid_q, new_res;
	logic    head_v_q, skid_v_q;
	logic    take, push, pop;

	assign seq_in.ready = !skid_v_q;
	assign take         = seq_in.valid && seq_in.ready;
	assign push         = take && seq_in.last_char;
	assign pop          = head_v_q && fp_out.ready;

	assign len_plus2 = len_q + word_t'(2);

	// (c+1)(L+2) = c(L+1) + c + L + 2 ; c(L+2) = c(L+1) + c
	always_comb begin
		for (int k = 0; k < NUM_BASES; k++) begin
			hit[k]    = (seq_in.base_char == BASE_CHARS[k]);
			cnt_n[k]  = cnt_q[k] + word_t'(hit[k]);
			pre_n[k]  = pre_q[k] + cnt_n[k];
			prod_n[k] = prod_q[k] + cnt_q[k] + (hit[k] ? len_plus2 : '0);
		end
		new_res.prefix = pre_n;
		new_res.prod   = prod_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pre_q  <= '0;
			prod_q <= '0;
			len_q  <= '0;
		end else if (take) begin
			if (seq_in.last_char) begin
				cnt_q  <= '0;
				pre_q  <= '0;
				prod_q <= '0;
				len_q  <= '0;
			end else begin
				cnt_q  <= cnt_n;
				pre_q  <= pre_n;
				prod_q <= prod_n;
				len_q  <= len_q + word_t'(1);
			end
		end
	end

	// Two-entry result buffer; a push never meets a full skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= new_res;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_q <= new_res;
			end else begin
				skid_q <= new_res;
			end
		end
	end

	assign fp_out.valid        = head_v_q;
	assign fp_out.prefix_sum_a = head_q.prefix[0];
	assign fp_out.prefix_sum_c = head_q.prefix[1];
	assign fp_out.prefix_sum_g = head_q.prefix[2];
	assign fp_out.prefix_sum_t = head_q.prefix[3];
	assign fp_out.suffix_sum_a = head_q.prod[0] - head_q.prefix[0];
	assign fp_out.suffix_sum_c = head_q.prod[1] - head_q.prefix[1];
	assign fp_out.suffix_sum_g = head_q.prod[2] - head_q.prefix[2];
	assign fp_out.suffix_sum_t = head_q.prod[3] - head_q.prefix[3];

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nucleotide_prefix_fingerprint. Character streams
// are pushed through seq_in with random gaps. Each accepted character
// updates a local copy of the base tallies. The fingerprint expected at the
// end of each sequence is checked word by word against every fp_out
// transfer. One long back-pressure window fills the result buffer so that
// seq_in stalls.
// ----------------------------------------------------------------------------
module tb;
	import npf_pkg::*;

	typedef struct {
		char_t ch;
		logic  last;
	} char_item_t;

	typedef struct {
		word_t prefix [NUM_BASES];
		word_t suffix [NUM_BASES];
	} fp_words_t;

	logic clk;
	logic arst_n;

	npf_char_if seq_in ();
	npf_fp_if   fp_out ();

	nucleotide_prefix_fingerprint u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.seq_in (seq_in),
		.fp_out (fp_out)
	);

	char_item_t char_q [$];
	fp_words_t  fp_expected [$];

	word_t base_tally [NUM_BASES];
	word_t prefix_tally [NUM_BASES];
	word_t seq_len;

	int   err_cnt   = 0;
	int   cycle     = 0;
	int   hold_left = 0;
	bit   in_taken  = 0;
	logic calm;

	// Both sides run without gaps inside this window.
	assign calm = (cycle >= 1200) && (cycle < 1700);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n           = 1'b0;
		seq_in.valid     = 1'b0;
		seq_in.base_char = '0;
		seq_in.last_char = 1'b0;
		fp_out.ready     = 1'b0;
		repeat (3) @(posedge clk);
		#2 arst_n = 1'b1;
	end

	initial begin
		#2ms;
		$display("[nucleotide_prefix_fingerprint] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
	end

	task automatic clear_tally();
		for (int k = 0; k < NUM_BASES; k++) begin
			base_tally[k]   = '0;
			prefix_tally[k] = '0;
		end
		seq_len = '0;
	endtask

	// Fold one accepted character into the tallies; close the sequence on last.
	task automatic absorb_char(input char_t ch, input logic last);
		fp_words_t fp;
		word_t     span;
		seq_len = seq_len + 1;
		for (int k = 0; k < NUM_BASES; k++)
			if (ch == BASE_CHARS[k])
				base_tally[k] = base_tally[k] + 1;
		for (int k = 0; k < NUM_BASES; k++)
			prefix_tally[k] = prefix_tally[k] + base_tally[k];
		if (last) begin
			span = seq_len + 1;
			for (int k = 0; k < NUM_BASES; k++) begin
				fp.prefix[k] = prefix_tally[k];
				fp.suffix[k] = base_tally[k] * span - prefix_tally[k];
			end
			fp_expected.push_back(fp);
			clear_tally();
		end
	endtask

	task automatic check_word(input string label, input word_t exp_w, input word_t act_w);
		if (exp_w !== act_w) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, label, exp_w, act_w);
			err_cnt++;
		end
	endtask

	task automatic queue_char(input char_t ch, input logic last);
		char_item_t it;
		it.ch   = ch;
		it.last = last;
		char_q.push_back(it);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(char_t'(s[i]), i == s.len() - 1);
	endtask

	// Input side: track transfers into the block.
	always @(posedge clk) begin
		if (arst_n && seq_in.valid && seq_in.ready) begin
			absorb_char(seq_in.base_char, seq_in.last_char);
			in_taken = 1'b1;
		end
	end

	// Character driver.
	always @(negedge clk) begin : drv
		char_item_t nxt;
		if (arst_n && (!seq_in.valid || in_taken)) begin
			if (char_q.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
				nxt = char_q.pop_front();
				seq_in.valid     <= 1'b1;
				seq_in.base_char <= nxt.ch;
				seq_in.last_char <= nxt.last;
			end else begin
				seq_in.valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// Result receiver; one long hold-off lets finished fingerprints pile up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			fp_out.ready <= 1'b0;
		end else if (cycle == 400) begin
			hold_left    <= 300;
			fp_out.ready <= 1'b0;
		end else begin
			fp_out.ready <= arst_n && (calm || $urandom_range(99) >= 38);
		end
	end

	// Result monitor.
	always @(posedge clk) begin : mon
		fp_words_t fp;
		if (arst_n && fp_out.valid && fp_out.ready) begin
			if (fp_expected.size() == 0) begin
				$display("%0t: unexpected fingerprint: expected none, actual %h %h %h %h %h %h %h %h",
					$time, fp_out.prefix_sum_a, fp_out.prefix_sum_c, fp_out.prefix_sum_g,
					fp_out.prefix_sum_t, fp_out.suffix_sum_a, fp_out.suffix_sum_c,
					fp_out.suffix_sum_g, fp_out.suffix_sum_t);
				err_cnt++;
			end else begin
				fp = fp_expected.pop_front();
				check_word("prefix_sum_a", fp.prefix[0], fp_out.prefix_sum_a);
				check_word("prefix_sum_c", fp.prefix[1], fp_out.prefix_sum_c);
				check_word("prefix_sum_g", fp.prefix[2], fp_out.prefix_sum_g);
				check_word("prefix_sum_t", fp.prefix[3], fp_out.prefix_sum_t);
				check_word("suffix_sum_a", fp.suffix[0], fp_out.suffix_sum_a);
				check_word("suffix_sum_c", fp.suffix[1], fp_out.suffix_sum_c);
				check_word("suffix_sum_g", fp.suffix[2], fp_out.suffix_sum_g);
				check_word("suffix_sum_t", fp.suffix[3], fp_out.suffix_sum_t);
			end
		end
	end

	initial begin : stim
		int    total;
		int    len;
		char_t ch;
		clear_tally();

		// Single-character sequences, including the all-zero and all-one bytes.
		queue_text("A");
		queue_text("C");
		queue_text("G");
		queue_text("T");
		queue_char(8'h00, 1'b1);
		queue_char(8'hFF, 1'b1);
		// Lowercase and other characters only advance the position.
		queue_text("acgt");
		queue_text("ACGT");
		queue_text("TTGCA-NA");
		queue_char(8'hFF, 1'b0);
		queue_char(8'h00, 1'b0);
		queue_char(CHAR_A, 1'b1);

		total = char_q.size();
		while (total < 1000) begin
			case ($urandom_range(99)) inside
				[0:79]:  len = $urandom_range(1, 12);
				[80:94]: len = $urandom_range(13, 60);
				default: len = $urandom_range(61, 300);
			endcase
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 80)
					ch = BASE_CHARS[$urandom_range(NUM_BASES - 1)];
				else
					ch = char_t'($urandom_range(255));
				queue_char(ch, i == len - 1);
			end
			total += len;
		end

		while (char_q.size() > 0 || seq_in.valid || fp_expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (err_cnt == 0)
			$display("[nucleotide_prefix_fingerprint] OK");
		else
			$display("[nucleotide_prefix_fingerprint] ERROR");
		$finish;
	end

endmodule
